>>> src/utf8_to_utf16_stream_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define U8U16_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Shared types, code point limits and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  // Code point limits used by the sequence checks
  localparam logic [20:0] CpMin2     = 21'h000080;
  localparam logic [20:0] CpMin3     = 21'h000800;
  localparam logic [20:0] CpNonchar  = 21'h00FFFE;
  localparam logic [20:0] CpSurrLow  = 21'h00D800;
  localparam logic [20:0] CpSurrHigh = 21'h00DFFF;
  localparam logic [20:0] CpBom      = 21'h00FEFF;
  localparam logic [20:0] CpMin4     = 21'h010000;
  localparam logic [20:0] CpMax      = 21'h10FFFF;

  // Surrogate pair bases
  localparam logic [15:0] HighSurrBase = 16'hD800;
  localparam logic [15:0] LowSurrBase  = 16'hDC00;

  // Replacement unit after reset
  localparam logic [15:0] ReplReset = 16'd63;

  // Result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // One UTF-16 result unit
  typedef struct packed {
    logic [15:0] code;
    logic        replaced;
    logic        last;
  } unit_t;

  // Up to two units produced by one byte
  typedef struct packed {
    logic [1:0] count;
    unit_t      u0;
    unit_t      u1;
  } unit_list_t;

  // Decoder state carried between bytes
  typedef struct packed {
    logic [20:0] partial;
    logic [3:0]  expected;
    logic [3:0]  seq_len;
    logic        at_start;
  } dec_state_t;

  // Count the leading one bits of a byte (0 to 8)
  function automatic logic [3:0] lead_len(input logic [7:0] b);
    logic [3:0] len;
    if (!b[7]) begin
      len = 4'd0;
    end else if (!b[6]) begin
      len = 4'd1;
    end else if (!b[5]) begin
      len = 4'd2;
    end else if (!b[4]) begin
      len = 4'd3;
    end else if (!b[3]) begin
      len = 4'd4;
    end else if (!b[2]) begin
      len = 4'd5;
    end else if (!b[1]) begin
      len = 4'd6;
    end else if (!b[0]) begin
      len = 4'd7;
    end else begin
      len = 4'd8;
    end
    return len;
  endfunction

  // Append a unit to the list; a full list drops it
  function automatic unit_list_t push_unit(input unit_list_t lst, input logic [15:0] code,
                                           input logic replaced);
    unit_list_t r;
    unit_t      x;
    r          = lst;
    x.code     = code;
    x.replaced = replaced;
    x.last     = 1'b0;
    if (lst.count == 2'd0) begin
      r.u0    = x;
      r.count = 2'd1;
    end else if (lst.count == 2'd1) begin
      r.u1    = x;
      r.count = 2'd2;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/u8u16_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 byte decode step
// Combines one byte with the decoder state and gives the next state and the
// zero to two UTF-16 units that the byte releases.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode (
  input  wire u8u16_pkg::dec_state_t st,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  end_of_stream,
  input  wire logic [15:0]           repl,
  output u8u16_pkg::dec_state_t      nxt,
  output u8u16_pkg::unit_list_t      units
);

  logic [20:0] v;
  logic [20:0] s;
  logic [3:0]  exp_dec;
  logic [3:0]  len;
  logic        pending;
  logic        cont;
  logic        ok;

  // Gather the continuation payload and the supplementary offset
  assign v       = {st.partial[14:0], data_byte[5:0]};
  assign s       = v - u8u16_pkg::CpMin4;
  assign exp_dec = st.expected - 4'd1;
  assign pending = (st.expected != 4'd0);
  assign cont    = (data_byte[7:6] == 2'b10);
  assign len     = u8u16_pkg::lead_len(data_byte);

  // Decode one byte
  always_comb begin
    nxt   = st;
    units = '0;
    ok    = 1'b0;
    if (pending && cont) begin
      if (exp_dec == 4'd0) begin
        // Check the finished sequence
        case (st.seq_len)
          4'd2: begin
            ok = (v >= u8u16_pkg::CpMin2);
            if (ok) begin
              units = u8u16_pkg::push_unit(units, v[15:0], 1'b0);
            end
          end
          4'd3: begin
            ok = (v >= u8u16_pkg::CpMin3) && (v < u8u16_pkg::CpNonchar) &&
                 !((v >= u8u16_pkg::CpSurrLow) && (v <= u8u16_pkg::CpSurrHigh));
            if (ok && !((v == u8u16_pkg::CpBom) && st.at_start)) begin
              units = u8u16_pkg::push_unit(units, v[15:0], 1'b0);
            end
          end
          4'd4: begin
            ok = (v >= u8u16_pkg::CpMin4) && (v <= u8u16_pkg::CpMax);
            if (ok) begin
              units = u8u16_pkg::push_unit(units,
                        u8u16_pkg::HighSurrBase + {6'd0, s[19:10]}, 1'b0);
              units = u8u16_pkg::push_unit(units,
                        u8u16_pkg::LowSurrBase + {6'd0, s[9:0]}, 1'b0);
            end
          end
          default: begin
            ok = 1'b0;
          end
        endcase
        if (!ok) begin
          units = u8u16_pkg::push_unit(units, repl, 1'b1);
        end
        nxt.at_start = 1'b0;
        nxt.partial  = '0;
        nxt.expected = '0;
        nxt.seq_len  = '0;
      end else begin
        // Keep collecting
        nxt.partial  = v;
        nxt.expected = exp_dec;
      end
    end else begin
      // Replace a sequence broken by this byte
      if (pending) begin
        units        = u8u16_pkg::push_unit(units, repl, 1'b1);
        nxt.partial  = '0;
        nxt.expected = '0;
        nxt.seq_len  = '0;
        nxt.at_start = 1'b0;
      end
      // Start a new character
      if (len == 4'd0) begin
        units        = u8u16_pkg::push_unit(units, {8'd0, data_byte}, 1'b0);
        nxt.at_start = 1'b0;
      end else if (len == 4'd1) begin
        units        = u8u16_pkg::push_unit(units, repl, 1'b1);
        nxt.at_start = 1'b0;
      end else begin
        nxt.seq_len  = len;
        nxt.expected = len - 4'd1;
        if (len == 4'd2) begin
          nxt.partial = {16'd0, data_byte[4:0]};
        end else if (len == 4'd3) begin
          nxt.partial = {17'd0, data_byte[3:0]};
        end else if (len == 4'd4) begin
          nxt.partial = {18'd0, data_byte[2:0]};
        end else begin
          nxt.partial = '0;
        end
      end
    end
    // Flush at end of stream and mark the final unit
    if (end_of_stream) begin
      if (nxt.expected != 4'd0) begin
        units = u8u16_pkg::push_unit(units, repl, 1'b1);
      end
      nxt.partial  = '0;
      nxt.expected = '0;
      nxt.seq_len  = '0;
      nxt.at_start = 1'b1;
      if (units.count == 2'd1) begin
        units.u0.last = 1'b1;
      end else if (units.count == 2'd2) begin
        units.u1.last = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/utf8_to_utf16_stream_decoder_core.sv
// A byte accepted into the input register is decoded there; once the queue has room,
// its units are written into the result queue and the oldest is offered on the output.
// Throughput: one byte per cycle while the queue has room for two units; the output
// takes one unit per cycle while out_ready is high, so a run of two-unit bytes stalls input.
// Reset (rst, synchronous): clears decoder state, arms the byte-order-mark
// skip, empties the queue and sets the replacement unit to 63.
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 stream decoder
// Input register, combinational decode step and a small result queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_to_utf16_stream_decoder_core_assert.svh"

module utf8_to_utf16_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_stream,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      code_unit,
  output logic             was_replaced,
  output logic             last_unit,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int unsigned CntW = u8u16_pkg::FifoAw + 1;
  localparam logic [CntW-1:0] RoomLimit = CntW'(u8u16_pkg::FifoDepth - 2);

  logic [15:0]                   repl;
  logic                          stage_valid;
  logic [7:0]                    stage_byte;
  logic                          stage_eos;
  logic                          stage_advance;
  u8u16_pkg::dec_state_t         st;
  u8u16_pkg::dec_state_t         st_next;
  u8u16_pkg::unit_list_t         dec_units;
  u8u16_pkg::unit_t              fifo [u8u16_pkg::FifoDepth];
  logic [u8u16_pkg::FifoAw-1:0]  wr_ptr;
  logic [u8u16_pkg::FifoAw-1:0]  rd_ptr;
  logic [CntW-1:0]               fifo_count;
  logic [CntW-1:0]               push_cnt;
  logic                          pop;

  // Advance the request only when the queue has room for two units
  assign stage_advance = stage_valid && (fifo_count <= RoomLimit);
  assign in_ready      = !stage_valid || stage_advance;
  assign pop           = out_valid && out_ready;
  assign push_cnt      = stage_advance ? CntW'(dec_units.count) : '0;

  // Hold the replacement unit
  always_ff @(posedge clk) begin
    if (rst) begin
      repl <= u8u16_pkg::ReplReset;
    end else if (cfg_we) begin
      repl <= cfg_wdata;
    end
  end

  // Capture the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= data_byte;
      stage_eos  <= end_of_stream;
    end
  end

  // Decode the held byte
  u8u16_decode u_decode (
    .st            (st),
    .data_byte     (stage_byte),
    .end_of_stream (stage_eos),
    .repl          (repl),
    .nxt           (st_next),
    .units         (dec_units)
  );

  // Update decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.partial  <= '0;
      st.expected <= '0;
      st.seq_len  <= '0;
      st.at_start <= 1'b1;
    end else if (stage_advance) begin
      st <= st_next;
    end
  end

  // Write decoded units into the queue
  always_ff @(posedge clk) begin
    if (stage_advance && (dec_units.count != 2'd0)) begin
      fifo[wr_ptr] <= dec_units.u0;
    end
    if (stage_advance && (dec_units.count == 2'd2)) begin
      fifo[wr_ptr + u8u16_pkg::FifoAw'(1)] <= dec_units.u1;
    end
  end

  // Advance queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + push_cnt[u8u16_pkg::FifoAw-1:0];
      rd_ptr     <= rd_ptr + u8u16_pkg::FifoAw'(pop);
      fifo_count <= fifo_count + push_cnt - CntW'(pop);
    end
  end

  // Offer the oldest unit
  assign out_valid    = (fifo_count != '0);
  assign code_unit    = fifo[rd_ptr].code;
  assign was_replaced = fifo[rd_ptr].replaced;
  assign last_unit    = fifo[rd_ptr].last;

  `U8U16_ASSERT_ALWAYS(a_fifo_bound, fifo_count <= CntW'(u8u16_pkg::FifoDepth),
    "result queue overflow")
  `U8U16_ASSERT_NEXT(a_push_visible, stage_advance && (dec_units.count != 2'd0),
    fifo_count != '0, "decoded unit lost from queue")
  `U8U16_ASSERT_ALWAYS(a_expected_range, (st.expected <= 4'd7) && (st.seq_len != 4'd1),
    "decoder state out of range")
  `U8U16_ASSERT_NEXT(a_eos_flush, stage_advance && stage_eos,
    st.at_start && (st.expected == 4'd0), "end of stream did not flush state")

endmodule

`default_nettype wire

>>> verif/utf16_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 unit checker
// Watches the byte, unit and replacement-write ports of the decoder. It keeps
// its own decode state, predicts the units of every accepted byte request and
// compares each unit handed over with the oldest prediction.
// ----------------------------------------------------------------------------
module utf16_unit_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_stream,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [15:0] code_unit,
  input  wire logic        was_replaced,
  input  wire logic        last_unit,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output int               mismatch_count,
  output int               units_pending
);

  // Decode state mirrored from the block
  logic [20:0] partial_cp;
  logic [3:0]  cont_left;
  logic [3:0]  lead_count;
  logic        stream_fresh;
  logic [15:0] repl_unit;

  u8u16_pkg::unit_t expected_units[$];
  u8u16_pkg::unit_t step_units[$];
  u8u16_pkg::unit_t want;

  // Append one unit to the current byte's output; a byte yields two at most
  task add_unit(input logic [15:0] code, input logic replaced);
    u8u16_pkg::unit_t u;
    u.code     = code;
    u.replaced = replaced;
    u.last     = 1'b0;
    if (step_units.size() < 2) step_units.push_back(u);
  endtask

  task drop_sequence();
    partial_cp = '0;
    cont_left  = '0;
    lead_count = '0;
  endtask

  // Check a completed sequence and emit its units or one replacement
  task end_sequence();
    logic [20:0] cp;
    logic [20:0] offs;
    logic        good;
    cp   = partial_cp;
    good = 1'b0;
    case (lead_count)
      4'd2: begin
        good = cp >= u8u16_pkg::CpMin2;
        if (good) add_unit(cp[15:0], 1'b0);
      end
      4'd3: begin
        good = cp >= u8u16_pkg::CpMin3 && cp < u8u16_pkg::CpNonchar &&
               !(cp >= u8u16_pkg::CpSurrLow && cp <= u8u16_pkg::CpSurrHigh);
        // drop a byte-order mark that opens the stream
        if (good && !(cp == u8u16_pkg::CpBom && stream_fresh)) add_unit(cp[15:0], 1'b0);
      end
      4'd4: begin
        good = cp >= u8u16_pkg::CpMin4 && cp <= u8u16_pkg::CpMax;
        if (good) begin
          offs = cp - u8u16_pkg::CpMin4;
          add_unit(u8u16_pkg::HighSurrBase + {6'd0, offs[19:10]}, 1'b0);
          add_unit(u8u16_pkg::LowSurrBase + {6'd0, offs[9:0]}, 1'b0);
        end
      end
      default: good = 1'b0;
    endcase
    if (!good) add_unit(repl_unit, 1'b1);
    stream_fresh = 1'b0;
    drop_sequence();
  endtask

  // Handle a byte that begins a character
  task start_char(input logic [7:0] b);
    int ones;
    ones = 0;
    while (ones < 8 && b[7 - ones]) ones++;
    if (ones == 0) begin
      add_unit({8'h00, b}, 1'b0);
      stream_fresh = 1'b0;
    end else if (ones == 1) begin
      // stray continuation byte
      add_unit(repl_unit, 1'b1);
      stream_fresh = 1'b0;
    end else begin
      lead_count = 4'(ones);
      cont_left  = 4'(ones - 1);
      partial_cp = (ones <= 4) ? 21'(b & (8'h7F >> ones)) : '0;
    end
  endtask

  // Predict the units of one accepted byte request and queue them
  task decode_byte(input logic [7:0] b, input logic eos);
    step_units.delete();
    if (cont_left != 0) begin
      if (b[7:6] == 2'b10) begin
        partial_cp = {partial_cp[14:0], b[5:0]};
        cont_left  = cont_left - 4'd1;
        if (cont_left == 0) end_sequence();
      end else begin
        // breaking byte: replace the open sequence, then start over
        add_unit(repl_unit, 1'b1);
        drop_sequence();
        stream_fresh = 1'b0;
        start_char(b);
      end
    end else begin
      start_char(b);
    end
    if (eos) begin
      if (cont_left != 0) add_unit(repl_unit, 1'b1);
      drop_sequence();
      stream_fresh = 1'b1;
      if (step_units.size() > 0) step_units[step_units.size() - 1].last = 1'b1;
    end
    foreach (step_units[i]) expected_units.push_back(step_units[i]);
  endtask

  task note_mismatch(input string what, input u8u16_pkg::unit_t exp_unit);
    if (mismatch_count < 10)
      $display("%0t: %s: expected code %h repl %b last %b, got code %h repl %b last %b",
               $time, what, exp_unit.code, exp_unit.replaced, exp_unit.last,
               code_unit, was_replaced, last_unit);
    mismatch_count++;
  endtask

  // Compare handed-over units, then advance the prediction
  always @(posedge clk) begin
    if (rst) begin
      drop_sequence();
      stream_fresh = 1'b1;
      repl_unit    = u8u16_pkg::ReplReset;
      expected_units.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_units.size() == 0) begin
          note_mismatch("unit with no request behind it", '0);
        end else begin
          want = expected_units.pop_front();
          if (code_unit !== want.code || was_replaced !== want.replaced ||
              last_unit !== want.last)
            note_mismatch("unit mismatch", want);
        end
      end
      if (in_valid && in_ready) decode_byte(data_byte, end_of_stream);
      if (cfg_we) repl_unit = cfg_wdata;
    end
    units_pending = expected_units.size();
  end

endmodule

>>> verif/utf8_to_utf16_stream_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder testbench
// Feeds directed and random UTF-8 byte streams under random back-pressure,
// changes the replacement unit between phases and leaves the checking to the
// unit checker that sits beside the decoder.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_core_tb;

  localparam int StallLimit = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        was_replaced;
  logic        last_unit;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  int mismatch_count;
  int units_pending;
  int bytes_sent = 0;
  int hold_cycles = 0;
  int quiet_count = 0;
  bit idle_on = 1'b1;

  logic [7:0] char_bytes[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  utf8_to_utf16_stream_decoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_unit     (code_unit),
    .was_replaced  (was_replaced),
    .last_unit     (last_unit),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  utf16_unit_checker unit_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_stream  (end_of_stream),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code_unit      (code_unit),
    .was_replaced   (was_replaced),
    .last_unit      (last_unit),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .units_pending  (units_pending)
  );

  // Unit receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= idle_on ? ($urandom_range(99) >= 32) : 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Offer one byte request and hold it until accepted; returns at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic eos);
    if (idle_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Encode a value with an n-byte lead pattern (n from 2 to 8)
  task automatic queue_point(input int unsigned cp, input int n);
    char_bytes.push_back(8'((8'hFF << (8 - n)) | ((cp >> (6 * (n - 1))) & (8'h7F >> n))));
    for (int k = n - 2; k >= 0; k--)
      char_bytes.push_back(8'(8'h80 | ((cp >> (6 * k)) & 8'h3F)));
  endtask

  // Build one random character, mostly well formed, and send its bytes
  task automatic send_char();
    int kind;
    int n;
    int unsigned cp;
    char_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 28) begin
      char_bytes.push_back(8'($urandom_range(127)));
    end else if (kind < 40) begin
      queue_point($urandom_range('h7FF, 'h80), 2);
    end else if (kind < 58) begin
      n = $urandom_range(15);
      if (n < 2) cp = 'hFEFF;
      else if (n < 4) cp = $urandom_range('hDFFF, 'hD800);
      else if (n < 5) cp = $urandom_range('hFFFF, 'hFFFE);
      else cp = $urandom_range('hFFFF, 'h800);
      queue_point(cp, 3);
    end else if (kind < 72) begin
      if ($urandom_range(5) == 0) cp = $urandom_range('h1FFFFF, 'h110000);
      else cp = $urandom_range('h10FFFF, 'h10000);
      queue_point(cp, 4);
    end else if (kind < 78) begin
      // overlong form of a value that fits a shorter sequence
      n = $urandom_range(4, 2);
      cp = (n == 2) ? $urandom_range('h7F) : (n == 3) ? $urandom_range('h7FF)
                                                      : $urandom_range('hFFFF);
      queue_point(cp, n);
    end else if (kind < 84) begin
      queue_point($urandom(), $urandom_range(8, 5));
    end else if (kind < 92) begin
      // sequence cut short; the next byte breaks it
      n = $urandom_range(4, 2);
      queue_point($urandom_range('h10FFFF, 'h80), n);
      repeat ($urandom_range(n - 1, 1)) void'(char_bytes.pop_back());
    end else begin
      repeat ($urandom_range(3, 1)) char_bytes.push_back(8'($urandom_range(255)));
    end
    foreach (char_bytes[i])
      push_byte(char_bytes[i], (i == char_bytes.size() - 1) ? ($urandom_range(11) == 0)
                                                          : ($urandom_range(39) == 0));
  endtask

  // Drop valid, wait for every predicted unit, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (units_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One phase: new replacement unit, then random characters
  task automatic run_phase(input logic [15:0] repl, input int count, input bit quiet_start,
                           input bit squeeze);
    int stop;
    bit squeezed;
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= repl;
    @(negedge clk);
    cfg_we   <= 1'b0;
    stop     = bytes_sent + count;
    squeezed = 1'b0;
    idle_on  = !quiet_start;
    while (bytes_sent < stop) begin
      if (quiet_start && bytes_sent >= stop - count + 200) idle_on = 1'b1;
      if (squeeze && !squeezed && bytes_sent >= stop - count / 2) begin
        hold_cycles = 150;
        squeezed    = 1'b1;
      end
      send_char();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: leading byte-order mark, overlong, 3-byte, surrogate,
    // noncharacter, surrogate pair, above range, stray, 8-byte lead broken
    // by a zero byte, truncated at end of stream
    push_byte(8'hEF, 1'b0); push_byte(8'hBB, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b0);
    push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hEF, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBE, 1'b0);
    push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0); push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hF4, 1'b0); push_byte(8'h90, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hC3, 1'b1);

    run_phase(16'hFFFD, 420, 1'b1, 1'b0);
    run_phase(16'h0000, 420, 1'b0, 1'b1);
    run_phase(16'hFFFF, 420, 1'b0, 1'b0);
    run_phase(16'($urandom_range(16'hFFFF)), 420, 1'b0, 1'b0);

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
